/* rtl/core/set_assoc_tag_array_lru_unit_macros.svh */
// ----------------------------------------------------------------------------
// set_assoc_tag_array_lru_unit_macros.svh
// assertion macros used by the tag array rtl
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_TAG_ARRAY_LRU_UNIT_MACROS_SVH
`define SET_ASSOC_TAG_ARRAY_LRU_UNIT_MACROS_SVH

// same-cycle check, off while in reset
`define SALRU_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, off while in reset
`define SALRU_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/salru_pkg.sv */
// ----------------------------------------------------------------------------
// salru_pkg
// transaction types and command codes of the set-associative tag array
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    // request transaction
    typedef struct packed {
        logic        cmd;
        logic [31:0] addr;
    } salru_req_t;

    // response transaction
    typedef struct packed {
        logic       hit;
        logic [1:0] way;
    } salru_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/salru_row_ram.sv */
// ----------------------------------------------------------------------------
// salru_row_ram
// one row per set, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module salru_row_ram #(
    parameter int ADDR_W = 6,
    parameter int DEPTH  = 64,
    parameter int ROW_W  = 116
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old row on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/salru_way_logic.sv */
// ----------------------------------------------------------------------------
// salru_way_logic
// tag compare, victim choice and age update for one set
// ----------------------------------------------------------------------------
`default_nettype none

module salru_way_logic
    import salru_pkg::*;
#(
    parameter int WAYS     = 4,
    parameter int AGE_BITS = 8,
    parameter int TAG_BITS = 20,
    parameter int WAY_W    = 2
) (
    input  logic                     cmd,
    input  logic [TAG_BITS-1:0]      tag,
    input  logic [WAYS-1:0]          valid,
    input  logic [WAYS*AGE_BITS-1:0] age,
    input  logic [WAYS*TAG_BITS-1:0] tags,
    output logic [WAYS-1:0]          new_valid,
    output logic [WAYS*AGE_BITS-1:0] new_age,
    output logic [WAYS*TAG_BITS-1:0] new_tags,
    output salru_rsp_t               result
);

    localparam int LVLS = $clog2(WAYS);
    localparam int P    = 1 << LVLS;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    logic [AGE_BITS-1:0] t_age [LVLS+1][P];
    logic [WAY_W-1:0]    t_idx [LVLS+1][P];
    logic                hit_found;
    logic [WAY_W-1:0]    hit_idx;
    logic                inv_found;
    logic [WAY_W-1:0]    inv_idx;
    logic                lookup_hit;
    logic [WAY_W-1:0]    target;

    // lowest matching way and lowest invalid way
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        inv_found = 1'b0;
        inv_idx   = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!hit_found && valid[i] && (tags[i*TAG_BITS +: TAG_BITS] == tag))
            begin
                hit_found = 1'b1;
                hit_idx   = WAY_W'(i);
            end
            if (!inv_found && !valid[i])
            begin
                inv_found = 1'b1;
                inv_idx   = WAY_W'(i);
            end
        end
    end

    // oldest way, pairwise tree, lower index wins ties
    always_comb
    begin
        for (int l = 0; l <= LVLS; l++)
        begin
            for (int k = 0; k < P; k++)
            begin
                t_age[l][k] = '0;
                t_idx[l][k] = '0;
            end
        end
        for (int k = 0; k < WAYS; k++)
        begin
            t_age[0][k] = age[k*AGE_BITS +: AGE_BITS];
            t_idx[0][k] = WAY_W'(k);
        end
        for (int l = 0; l < LVLS; l++)
        begin
            for (int k = 0; k < P / 2; k++)
            begin
                if (k < (P >> (l + 1)))
                begin
                    if (t_age[l][2*k+1] > t_age[l][2*k])
                    begin
                        t_age[l+1][k] = t_age[l][2*k+1];
                        t_idx[l+1][k] = t_idx[l][2*k+1];
                    end
                    else
                    begin
                        t_age[l+1][k] = t_age[l][2*k];
                        t_idx[l+1][k] = t_idx[l][2*k];
                    end
                end
            end
        end
    end

    assign lookup_hit = (cmd == CMD_LOOKUP) && hit_found;

    always_comb
    begin
        if (lookup_hit)
        begin
            target = hit_idx;
        end
        else if (inv_found)
        begin
            target = inv_idx;
        end
        else
        begin
            target = t_idx[LVLS][0];
        end
    end

    // allocate on miss or fill, age the whole set, clear the touched way
    always_comb
    begin
        new_valid = valid;
        new_tags  = tags;
        for (int i = 0; i < WAYS; i++)
        begin
            if (WAY_W'(i) == target)
            begin
                new_age[i*AGE_BITS +: AGE_BITS] = '0;
                if (!lookup_hit)
                begin
                    new_valid[i]                    = 1'b1;
                    new_tags[i*TAG_BITS +: TAG_BITS] = tag;
                end
            end
            else if (age[i*AGE_BITS +: AGE_BITS] == AGE_MAX)
            begin
                new_age[i*AGE_BITS +: AGE_BITS] = AGE_MAX;
            end
            else
            begin
                new_age[i*AGE_BITS +: AGE_BITS] = age[i*AGE_BITS +: AGE_BITS] + 1'b1;
            end
        end
    end

    assign result.hit = lookup_hit;
    assign result.way = 2'(target);

endmodule

`default_nettype wire

/* rtl/core/set_assoc_tag_array_lru_unit.sv */
// ----------------------------------------------------------------------------
// set_assoc_tag_array_lru_unit
// tag array of a set-associative cache with least-recently-used replacement
// ----------------------------------------------------------------------------
//
//  channel | signals                  | direction | transaction
//  --------+--------------------------+-----------+----------------------------
//  req     | req_valid, req_stall,req | in        | cmd and byte address
//  rsp     | rsp_valid, rsp_stall,rsp | out       | hit flag and way
//
//  one transaction per cycle while req_stall is low; each request has its
//  set row read from the row ram, then compare and update into the result
//  register; back-to-back accesses to one set go through a row bypass
//  after reset a clearing pass zeroes valid and age of every set, one set a
//  cycle, with req_stall held high
//  a stalled result holds the update stage, and req_stall rises when that
//  stage is full and cannot move on
//
`default_nettype none

module set_assoc_tag_array_lru_unit
    import salru_pkg::*;
#(
    parameter int WAYS           = 4,
    parameter int SET_INDEX_BITS = 6,
    parameter int OFFSET_BITS    = 6,
    parameter int ADDR_BITS      = 32,
    parameter int AGE_BITS       = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  salru_req_t req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output salru_rsp_t rsp
);

    `include "set_assoc_tag_array_lru_unit_macros.svh"

    // address split
    localparam int EFF_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam int TAG_SHIFT = OFFSET_BITS + SET_INDEX_BITS;
    localparam int TAG_BITS = (EFF_BITS > TAG_SHIFT) ? (EFF_BITS - TAG_SHIFT) : 1;
    localparam logic [31:0] ADDR_MASK = 32'((64'(1) << EFF_BITS) - 64'(1));
    localparam int NUM_SETS = 1 << SET_INDEX_BITS;
    localparam int SET_W = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // row layout: tags, ages, valid bits
    localparam int VAL_LO = 0;
    localparam int AGE_LO = WAYS;
    localparam int TAG_LO = WAYS + WAYS * AGE_BITS;
    localparam int ROW_W  = TAG_LO + WAYS * TAG_BITS;

    logic [31:0]         req_addr;
    logic [SET_W-1:0]    req_set;
    logic [TAG_BITS-1:0] req_tag;
    logic                accept;

    // update stage
    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [SET_W-1:0]    s1_set_reg;
    logic [TAG_BITS-1:0] s1_tag_reg;
    logic                s1_adv;

    // row bypass for back-to-back accesses to one set
    logic                fwd_valid_reg;
    logic [ROW_W-1:0]    fwd_row_reg;

    // clearing pass
    logic                clr_active_reg;
    logic [SET_W-1:0]    clr_idx_reg;

    // result register
    logic                out_valid_reg;
    salru_rsp_t          out_data_reg;

    logic [ROW_W-1:0]    ram_rd_data;
    logic [ROW_W-1:0]    cur_row;
    logic [ROW_W-1:0]    new_row;
    logic                ram_wr_en;
    logic [SET_W-1:0]    ram_wr_addr;
    logic [ROW_W-1:0]    ram_wr_data;
    logic [WAYS-1:0]          upd_valid;
    logic [WAYS*AGE_BITS-1:0] upd_age;
    logic [WAYS*TAG_BITS-1:0] upd_tags;
    salru_rsp_t          upd_rsp;

    assign req_addr = req.addr & ADDR_MASK;
    assign req_set  = (SET_INDEX_BITS == 0) ? '0 : SET_W'(req_addr >> OFFSET_BITS);
    assign req_tag  = TAG_BITS'(req_addr >> TAG_SHIFT);

    // the update stage moves whenever the result register is free or drains
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = clr_active_reg || (s1_valid_reg && !s1_adv);
    assign accept    = req_valid && !req_stall;

    // clearing pass walks every set once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_idx_reg == SET_W'(NUM_SETS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    assign ram_wr_en   = clr_active_reg || s1_adv;
    assign ram_wr_addr = clr_active_reg ? clr_idx_reg : s1_set_reg;
    assign ram_wr_data = clr_active_reg ? '0 : new_row;

    salru_row_ram #(
        .ADDR_W (SET_W),
        .DEPTH  (NUM_SETS),
        .ROW_W  (ROW_W)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (req_set),
        .rd_data (ram_rd_data)
    );

    // update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg  <= 1'b1;
            // row being written this cycle is the one just read: ram has it stale
            fwd_valid_reg <= s1_adv && (s1_set_reg == req_set);
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= req.cmd;
            s1_set_reg  <= req_set;
            s1_tag_reg  <= req_tag;
            fwd_row_reg <= new_row;
        end
    end

    assign cur_row = fwd_valid_reg ? fwd_row_reg : ram_rd_data;

    salru_way_logic #(
        .WAYS     (WAYS),
        .AGE_BITS (AGE_BITS),
        .TAG_BITS (TAG_BITS),
        .WAY_W    (WAY_W)
    ) u_way_logic (
        .cmd       (s1_cmd_reg),
        .tag       (s1_tag_reg),
        .valid     (cur_row[VAL_LO +: WAYS]),
        .age       (cur_row[AGE_LO +: WAYS*AGE_BITS]),
        .tags      (cur_row[TAG_LO +: WAYS*TAG_BITS]),
        .new_valid (upd_valid),
        .new_age   (upd_age),
        .new_tags  (upd_tags),
        .result    (upd_rsp)
    );

    assign new_row = {upd_tags, upd_age, upd_valid};

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= upd_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // no transaction may be in flight while sets are being cleared
    `SALRU_CHECK(a_clear_idle, clr_active_reg, req_stall && !s1_valid_reg && !out_valid_reg, "transaction in flight during clearing pass")
    // a fill never reports a hit
    `SALRU_CHECK_NEXT(a_fill_no_hit, s1_adv && (s1_cmd_reg == CMD_FILL), !out_data_reg.hit, "fill reported a hit")
    // reported way lies inside the set
    `SALRU_CHECK(a_way_range, out_valid_reg, (WAYS > 4) || (32'(out_data_reg.way) < 32'(WAYS)), "way outside the set")
    // bypass only follows a write to the same set
    `SALRU_CHECK_NEXT(a_fwd_source, accept && !s1_adv, !fwd_valid_reg, "bypass without a preceding write")

endmodule

`default_nettype wire

/* sim/tb_set_assoc_tag_array_lru_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_tag_array_lru_unit
// self-checking bench for the set-associative tag array with lru replacement
//
// A queue of pending requests feeds a clocked driver. A shadow copy of the
// valid, tag and age arrays predicts the hit flag and way of every accepted
// request. A clocked monitor compares each response with the oldest
// prediction. Both channels see random gaps and stalls, one long response
// hold-off and two pauses of the sender until the array has drained.
// ----------------------------------------------------------------------------

module tb_set_assoc_tag_array_lru_unit;

    import salru_pkg::*;

    // geometry of the array as built
    localparam int N_WAYS   = 4;
    localparam int SET_BITS = 6;
    localparam int OFF_BITS = 6;
    localparam int TAG_W    = 32 - SET_BITS - OFF_BITS;
    localparam int AGE_W    = 8;
    localparam int N_SETS   = 1 << SET_BITS;

    // run control
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int HOLD_CYCLES  = 400;   // long response hold-off
    localparam int HOLD_AT      = 350;   // request count that starts it
    localparam int TAIL_CYCLES  = 8;
    localparam int N_RANDOM     = 900;
    localparam int MAX_REPORTS  = 10;

    // a request waiting to be driven; hold makes the driver wait for an
    // empty array pipeline before offering it
    typedef struct packed {
        logic       hold;
        salru_req_t req;
    } pending_req_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    salru_req_t req = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    salru_rsp_t rsp;

    // shadow copy of the tag array
    logic             shadow_valid [N_SETS][N_WAYS];
    logic [TAG_W-1:0] shadow_tag   [N_SETS][N_WAYS];
    logic [AGE_W-1:0] shadow_age   [N_SETS][N_WAYS];

    pending_req_t req_pending [$];
    salru_rsp_t   rsp_expected [$];

    int  mismatch_count = 0;
    int  req_count      = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    int  stall_cycle    = 0;
    int  idle_cycles    = 0;
    bit  hold_done      = 1'b0;
    bit  req_took;
    pending_req_t next_req;
    salru_rsp_t   want;

    set_assoc_tag_array_lru_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // lru bookkeeping
    // ------------------------------------------------------------------------

    // age every way of the set by one (saturating), then make the touched
    // way the youngest
    function automatic void age_set(int set_idx, int way_idx);
        for (int i = 0; i < N_WAYS; i++)
        begin
            if (shadow_age[set_idx][i] != {AGE_W{1'b1}})
                shadow_age[set_idx][i] = shadow_age[set_idx][i] + 1'b1;
        end
        shadow_age[set_idx][way_idx] = '0;
    endfunction

    // one access to the shadow array: lookup (allocating on a miss) or fill
    function automatic salru_rsp_t lru_access(salru_req_t r);
        int               set_idx;
        int               way_idx;
        logic [TAG_W-1:0] tag;
        logic             is_hit;
        logic             have_free;
        logic [AGE_W-1:0] oldest;
        salru_rsp_t       result;

        set_idx = int'(r.addr[OFF_BITS +: SET_BITS]);
        tag     = r.addr[31 -: TAG_W];
        is_hit  = 1'b0;
        way_idx = 0;

        // downward scan leaves the lowest matching way
        if (r.cmd == CMD_LOOKUP)
        begin
            for (int i = N_WAYS - 1; i >= 0; i--)
            begin
                if (shadow_valid[set_idx][i] && shadow_tag[set_idx][i] == tag)
                begin
                    is_hit  = 1'b1;
                    way_idx = i;
                end
            end
        end

        if (is_hit)
        begin
            age_set(set_idx, way_idx);
        end
        else
        begin
            // first free way, else the oldest, lowest index on ties
            have_free = 1'b0;
            for (int i = N_WAYS - 1; i >= 0; i--)
            begin
                if (!shadow_valid[set_idx][i])
                begin
                    have_free = 1'b1;
                    way_idx   = i;
                end
            end
            if (!have_free)
            begin
                way_idx = 0;
                oldest  = shadow_age[set_idx][0];
                for (int i = 1; i < N_WAYS; i++)
                begin
                    if (shadow_age[set_idx][i] > oldest)
                    begin
                        oldest  = shadow_age[set_idx][i];
                        way_idx = i;
                    end
                end
            end
            shadow_valid[set_idx][way_idx] = 1'b1;
            shadow_tag[set_idx][way_idx]   = tag;
            age_set(set_idx, way_idx);
        end

        result.hit = is_hit;
        result.way = way_idx[1:0];
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_raw(logic cmd, logic [31:0] addr, logic hold);
        pending_req_t p;
        p.hold     = hold;
        p.req.cmd  = cmd;
        p.req.addr = addr;
        req_pending.push_back(p);
    endfunction

    // access to a given set and tag with a random block offset
    function automatic void queue_access(logic cmd, logic [SET_BITS-1:0] set_idx,
                                         logic [TAG_W-1:0] tag, logic hold);
        logic [OFF_BITS-1:0] offset;
        offset = OFF_BITS'($urandom_range((1 << OFF_BITS) - 1));
        queue_raw(cmd, {tag, set_idx, offset}, hold);
    endfunction

    // idle length: mostly none or short, a few long, and quiet stretches
    function automatic int pick_gap(int n);
        int r;
        r = $urandom_range(99);
        if ((n % 300) < 80)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(15, 4);
        return $urandom_range(60, 20);
    endfunction

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // request driver
    // predicts on acceptance, so the shadow array follows the exact order in
    // which the block takes requests
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left  = 0;
        end
        else
        begin
            req_took = req_valid && !req_stall;
            if (req_took)
            begin
                rsp_expected.push_back(lru_access(req));
                req_count++;
            end
            // a stalled transaction keeps its payload and valid untouched
            if (!req_valid || req_took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_pending.size() != 0 &&
                         (!req_pending[0].hold ||
                          (rsp_expected.size() == 0 && !req_took)))
                begin
                    next_req  = req_pending.pop_front();
                    req       <= next_req.req;
                    req_valid <= 1'b1;
                    gap_left  = pick_gap(req_count);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // response stall generator
    // one long hold-off once enough requests went in, so the pipeline backs
    // up into req_stall; otherwise random stalls with quiet stretches
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall   <= 1'b0;
            stall_left  = 0;
            hold_left   = 0;
            stall_cycle = 0;
        end
        else
        begin
            stall_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && req_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if ((stall_cycle % 1000) >= 200 && $urandom_range(99) < 25)
            begin
                // most stalls short, a few long
                if ($urandom_range(99) < 90)
                    stall_left = $urandom_range(3, 1) - 1;
                else
                    stall_left = $urandom_range(40, 10) - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // response monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected response: hit %0d way %0d", rsp.hit, rsp.way);
            end
            else
            begin
                want = rsp_expected.pop_front();
                if (rsp.hit !== want.hit || rsp.way !== want.way)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("response mismatch: hit exp %0d got %0d, way exp %0d got %0d",
                                 want.hit, rsp.hit, want.way, rsp.way);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no transaction on either channel for too long
    // covers the clearing pass after reset and the long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("set_assoc_tag_array_lru_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TAG_W-1:0]    tag_pool [8];
        logic [SET_BITS-1:0] hot_sets [8];
        logic [SET_BITS-1:0] sat_set;
        logic [TAG_W-1:0]    sat_tag  [4];
        logic [SET_BITS-1:0] pick_set;
        int                  r;

        // shadow array after reset: nothing valid, all ages zero
        for (int s = 0; s < N_SETS; s++)
        begin
            for (int w = 0; w < N_WAYS; w++)
            begin
                shadow_valid[s][w] = 1'b0;
                shadow_tag[s][w]   = '0;
                shadow_age[s][w]   = '0;
            end
        end

        // directed part
        // empty set, then a hit on the same line through the far offset
        queue_raw(CMD_LOOKUP, 32'h0000_0000, 1'b0);
        queue_raw(CMD_LOOKUP, 32'h0000_003F, 1'b0);
        // fill up set 0 by misses
        queue_access(CMD_LOOKUP, 6'd0, 20'h00001, 1'b0);
        queue_access(CMD_LOOKUP, 6'd0, 20'h80000, 1'b0);
        queue_access(CMD_LOOKUP, 6'd0, 20'h7FFFF, 1'b0);
        // hit refreshes way 0, then a miss evicts the oldest way
        queue_access(CMD_LOOKUP, 6'd0, 20'h00000, 1'b0);
        queue_access(CMD_LOOKUP, 6'd0, 20'h12345, 1'b0);
        // fill of an evicted tag twice, then lookup picks the lowest copy
        queue_access(CMD_FILL,   6'd0, 20'h00001, 1'b0);
        queue_access(CMD_FILL,   6'd0, 20'h00001, 1'b0);
        queue_access(CMD_LOOKUP, 6'd0, 20'h00001, 1'b0);
        // all-ones address: miss, hit, duplicate fill, lowest copy
        queue_raw(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        queue_raw(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        queue_raw(CMD_FILL,   32'hFFFF_FFFF, 1'b0);
        queue_raw(CMD_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        // tag zero into the top set, tag all ones into set 0
        queue_raw(CMD_FILL,   32'h0000_0FC0, 1'b0);
        queue_raw(CMD_LOOKUP, 32'hFFFF_F000, 1'b0);
        queue_access(CMD_LOOKUP, 6'd42, 20'hAAAAA, 1'b0);
        queue_access(CMD_FILL,   6'd21, 20'h55555, 1'b0);
        // sender waits for an empty pipeline before this one
        queue_access(CMD_LOOKUP, 6'd21, 20'h55555, 1'b1);

        // random part: mostly a few hot sets and a small tag pool so that
        // hits, misses and evictions mix; the rest is raw noise
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            tag_pool[i] = TAG_W'($urandom_range((1 << TAG_W) - 1));
        for (int i = 0; i < 8; i++)
            hot_sets[i] = SET_BITS'($urandom_range(N_SETS - 1));

        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == N_RANDOM / 2)
            begin
                // one set hammered on a single way until the other ages
                // saturate, then misses pick among equal oldest ways
                sat_set = SET_BITS'($urandom_range(N_SETS - 1));
                for (int i = 0; i < 4; i++)
                begin
                    sat_tag[i] = TAG_W'($urandom_range((1 << TAG_W) - 1));
                    queue_access(CMD_FILL, sat_set, sat_tag[i], 1'b0);
                end
                for (int i = 0; i < 270; i++)
                    queue_access(CMD_LOOKUP, sat_set, sat_tag[1], 1'b0);
                for (int i = 0; i < 3; i++)
                    queue_access(CMD_LOOKUP, sat_set,
                                 TAG_W'($urandom_range((1 << TAG_W) - 1)), 1'b0);
            end
            r = $urandom_range(99);
            if (r < 12)
            begin
                queue_raw(1'($urandom_range(1)), $urandom, k == 700);
            end
            else
            begin
                if ($urandom_range(9) == 0)
                    pick_set = SET_BITS'($urandom_range(N_SETS - 1));
                else
                    pick_set = hot_sets[3'($urandom_range(7))];
                queue_access(($urandom_range(6) == 0) ? CMD_FILL : CMD_LOOKUP,
                             pick_set, tag_pool[3'($urandom_range(7))], k == 700);
            end
        end

        // reset, then the block clears its array on its own
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // everything driven and answered, then a short tail; checked away
        // from the active edge so the driver and monitor have settled
        while (req_pending.size() != 0 || req_valid || rsp_expected.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("set_assoc_tag_array_lru_unit: match");
        else
            $display("set_assoc_tag_array_lru_unit: mismatch");
        $finish;
    end

endmodule
